// ===== rtl/core/fps_pkg.sv =====
// Package for the flight phase sequencer: transaction structs, phase codes,
// configuration register indexes and reset values. No dependencies.
package fps_pkg;

    localparam int WINDOW_SIZE_DEF = 10;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BURN_TIME    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESCENT_TIME = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAUNCH_CODE  = 2'd2;

    localparam logic [31:0] BURN_TIME_RST    = 32'd5000;
    localparam logic [31:0] DESCENT_TIME_RST = 32'd300000;
    localparam logic [7:0]  LAUNCH_CODE_RST  = 8'd8;

    localparam logic [2:0] PH_WAITING = 3'd0;
    localparam logic [2:0] PH_POWERED = 3'd1;
    localparam logic [2:0] PH_COAST   = 3'd2;
    localparam logic [2:0] PH_DESCENT = 3'd3;
    localparam logic [2:0] PH_LANDED  = 3'd4;
    localparam logic [2:0] PH_ABORT   = 3'd5;

    localparam logic ACT_EVALUATE = 1'b0;
    localparam logic ACT_FORCE    = 1'b1;

    typedef struct packed {
        logic        action;
        logic [2:0]  forced_phase;
        logic [31:0] now_ms;
        logic [7:0]  last_command;
        logic [15:0] pressure_sample;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  phase;
        logic        phase_changed;
        logic [15:0] average_pressure;
    } t_out_item;

    // Request from the sequencer to the averaging window.
    typedef struct packed {
        logic        upd;
        logic [15:0] sample;
    } t_win_req;

endpackage

// ===== rtl/core/fps_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on fps_pkg only by convention; no package items are needed here.
module fps_divider #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, r_div};
        ge      = (shifted >= {1'b0, r_div});
        n_rem   = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/core/fps_window.sv =====
// Moving-average window store: sample memory, write position, fill count
// and running total. Depends on fps_pkg for the request struct.
module fps_window
    import fps_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int TOTAL_W     = 16 + $clog2(WINDOW_SIZE + 1),
    parameter int FILL_W      = $clog2(WINDOW_SIZE + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_win_req           i_req,
    output logic [TOTAL_W-1:0] o_total,
    output logic [FILL_W-1:0]  o_fill
);

    localparam int POS_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    logic [15:0]        r_mem [WINDOW_SIZE];
    logic [15:0]        r_rd_data;
    logic [POS_W-1:0]   r_pos;
    logic [FILL_W-1:0]  r_fill;
    logic [TOTAL_W-1:0] r_total;

    logic               full;
    logic [TOTAL_W-1:0] n_total;
    logic [POS_W-1:0]   n_pos;

    // Entries are read only once the window is full, so every read entry
    // has been written since reset and the memory itself needs no clear.
    always_comb begin
        full = (r_fill == FILL_W'(WINDOW_SIZE));
        if (full) begin
            n_total = r_total - TOTAL_W'(r_rd_data) + TOTAL_W'(i_req.sample);
        end else begin
            n_total = r_total + TOTAL_W'(i_req.sample);
        end
        if (r_pos == POS_W'(WINDOW_SIZE - 1)) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    // The read port follows the write position every cycle; the position
    // moves only on an update, so the oldest sample is always ready.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_pos];
        if (i_req.upd) begin
            r_mem[r_pos] <= i_req.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else if (i_req.upd) begin
            r_pos   <= n_pos;
            r_total <= n_total;
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign o_total = r_total;
    assign o_fill  = r_fill;

endmodule

// ===== rtl/core/flight_phase_sequencer.sv =====
// Flight phase sequencer top level: configuration registers, sequencer and
// output register. Depends on fps_pkg, fps_window and fps_divider.
//
// Usage: input transactions arrive on i_in_valid / i_in_item and are taken
// when o_in_stall is low. Each transaction yields exactly one result on
// o_out_valid / o_out_item, taken when i_out_stall is low. The block holds
// one transaction at a time and raises o_in_stall until it has moved that
// transaction's result into the output register.
// A forced phase or an evaluation outside coast passes from acceptance
// through the evaluate and finish states to o_out_valid. A coast evaluation
// also passes through the window update, divider start and divider wait
// states, where the serial divider forms the window average one quotient
// bit per cycle.
// A new transaction can be accepted while an earlier result still waits in
// the output register; a finished result waits inside until the register
// frees up, and no result is lost while the receiver stalls.
// Configuration writes on i_cfg_we take effect at the next clock edge.
// Reset returns the phase to waiting, clears entry time, averages and the
// window fill and total, and loads the default configuration.
module flight_phase_sequencer
    import fps_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item
);

    localparam int FILL_W  = $clog2(WINDOW_SIZE + 1);
    localparam int TOTAL_W = 16 + FILL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WIN_UPD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } t_state;

    t_state      r_state, n_state;
    t_in_item    r_item;
    logic [31:0] r_burn_time;
    logic [31:0] r_descent_time;
    logic [7:0]  r_launch_code;
    logic [2:0]  r_phase, n_phase;
    logic [31:0] r_entry, n_entry;
    logic [15:0] r_prev_avg, n_prev_avg;
    logic [15:0] r_latest_avg, n_latest_avg;
    logic        r_changed, n_changed;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    t_win_req           win_req;
    logic [TOTAL_W-1:0] win_total;
    logic [FILL_W-1:0]  win_fill;
    logic               div_start;
    logic               div_done;
    logic [TOTAL_W-1:0] div_quo;
    logic [31:0]        elapsed;
    logic [15:0]        avg;

    fps_window #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .TOTAL_W     (TOTAL_W),
        .FILL_W      (FILL_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (win_req),
        .o_total (win_total),
        .o_fill  (win_fill)
    );

    fps_divider #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (FILL_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (win_total),
        .i_divisor  (win_fill),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_entry      = r_entry;
        n_prev_avg   = r_prev_avg;
        n_latest_avg = r_latest_avg;
        n_changed    = r_changed;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;

        win_req.upd    = 1'b0;
        win_req.sample = r_item.pressure_sample;
        div_start      = 1'b0;
        elapsed        = r_item.now_ms - r_entry;
        avg            = div_quo[15:0];

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state   = ST_FINISH;
                n_changed = 1'b0;
                if (r_item.action == ACT_FORCE) begin
                    if (r_item.forced_phase <= PH_ABORT) begin
                        n_phase   = r_item.forced_phase;
                        n_entry   = r_item.now_ms;
                        n_changed = (r_item.forced_phase != r_phase);
                    end
                end else begin
                    case (r_phase)
                        PH_WAITING: begin
                            if (r_item.last_command == r_launch_code) begin
                                n_phase   = PH_POWERED;
                                n_entry   = r_item.now_ms;
                                n_changed = 1'b1;
                            end
                        end
                        PH_POWERED: begin
                            if (elapsed > r_burn_time) begin
                                n_phase   = PH_COAST;
                                n_entry   = r_item.now_ms;
                                n_changed = 1'b1;
                            end
                        end
                        PH_COAST: begin
                            n_state = ST_WIN_UPD;
                        end
                        PH_DESCENT: begin
                            if (elapsed > r_descent_time) begin
                                n_phase   = PH_LANDED;
                                n_entry   = r_item.now_ms;
                                n_changed = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WIN_UPD: begin
                win_req.upd = 1'b1;
                n_state     = ST_DIV_START;
            end
            ST_DIV_START: begin
                div_start = 1'b1;
                n_state   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state      = ST_FINISH;
                    n_latest_avg = avg;
                    // On the apogee item the previous average keeps its value.
                    if ((r_prev_avg != 16'd0) && (avg > r_prev_avg)) begin
                        n_phase   = PH_DESCENT;
                        n_entry   = r_item.now_ms;
                        n_changed = 1'b1;
                    end else begin
                        n_prev_avg = avg;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.phase            = r_phase;
                    n_out.phase_changed    = r_changed;
                    n_out.average_pressure = r_latest_avg;
                    n_out_valid            = 1'b1;
                    n_state                = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_burn_time    <= BURN_TIME_RST;
            r_descent_time <= DESCENT_TIME_RST;
            r_launch_code  <= LAUNCH_CODE_RST;
            r_phase        <= PH_WAITING;
            r_entry        <= '0;
            r_prev_avg     <= '0;
            r_latest_avg   <= '0;
            r_changed      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_entry      <= n_entry;
            r_prev_avg   <= n_prev_avg;
            r_latest_avg <= n_latest_avg;
            r_changed    <= n_changed;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BURN_TIME:    r_burn_time    <= i_cfg_data;
                    CFG_DESCENT_TIME: r_descent_time <= i_cfg_data;
                    CFG_LAUNCH_CODE:  r_launch_code  <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
        r_out <= n_out;
        if (r_state == ST_IDLE && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== tb/sv/tb_flight_phase_sequencer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for flight_phase_sequencer: a scoreboard class predicts
// every result, and plain tasks drive input and configuration. Depends on fps_pkg.

import fps_pkg::*;

class phase_scoreboard;
    localparam int WIN_LEN = WINDOW_SIZE_DEF;

    logic [31:0] burn_ms;
    logic [31:0] descent_ms;
    logic [7:0]  launch_cmd;

    logic [2:0]  phase;
    logic [31:0] entered_at;
    logic [15:0] prev_avg;
    logic [15:0] last_avg;
    logic [15:0] win [WIN_LEN];
    int unsigned win_pos;
    int unsigned win_fill;
    logic [19:0] win_sum;

    t_out_item   expected_phases[$];
    int          errors;

    function new();
        burn_ms    = BURN_TIME_RST;
        descent_ms = DESCENT_TIME_RST;
        launch_cmd = LAUNCH_CODE_RST;
        phase      = PH_WAITING;
        entered_at = '0;
        prev_avg   = '0;
        last_avg   = '0;
        foreach (win[i]) win[i] = '0;
        win_pos    = 0;
        win_fill   = 0;
        win_sum    = '0;
        errors     = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_BURN_TIME:    burn_ms = data;
            CFG_DESCENT_TIME: descent_ms = data;
            CFG_LAUNCH_CODE:  launch_cmd = data[7:0];
            default: ;
        endcase
    endfunction

    // Adds one pressure sample to the moving window and returns the new mean.
    function logic [15:0] fold_pressure(logic [15:0] sample);
        if (win_fill < WIN_LEN)
            win_fill++;
        else
            win_sum -= 20'(win[win_pos]);
        win[win_pos] = sample;
        win_sum += 20'(sample);
        win_pos = (win_pos + 1 == WIN_LEN) ? 0 : win_pos + 1;
        return 16'(win_sum / 20'(win_fill));
    endfunction

    function void note_input(t_in_item it);
        logic [2:0]  prior;
        logic [2:0]  nxt;
        logic [31:0] elapsed;
        logic [15:0] avg;
        t_out_item   e;
        prior   = phase;
        nxt     = prior;
        elapsed = it.now_ms - entered_at;
        if (it.action == ACT_FORCE) begin
            // Codes 6 and 7 are not phases and leave everything alone.
            if (it.forced_phase <= PH_ABORT) begin
                phase      = it.forced_phase;
                entered_at = it.now_ms;
            end
        end else begin
            case (prior)
                PH_WAITING: begin
                    if (it.last_command == launch_cmd) nxt = PH_POWERED;
                end
                PH_POWERED: begin
                    if (elapsed > burn_ms) nxt = PH_COAST;
                end
                PH_COAST: begin
                    avg      = fold_pressure(it.pressure_sample);
                    last_avg = avg;
                    // The previous average is held on the apogee transaction.
                    if (prev_avg != 0 && avg > prev_avg)
                        nxt = PH_DESCENT;
                    else
                        prev_avg = avg;
                end
                PH_DESCENT: begin
                    if (elapsed > descent_ms) nxt = PH_LANDED;
                end
                default: ;
            endcase
            if (nxt != prior) begin
                phase      = nxt;
                entered_at = it.now_ms;
            end
        end
        e.phase            = phase;
        e.phase_changed    = (phase != prior);
        e.average_pressure = last_avg;
        expected_phases.push_back(e);
    endfunction

    function void check_result(t_out_item got);
        t_out_item e;
        if (expected_phases.size() == 0) begin
            $display("%0t: result with nothing expected, actual phase %0d changed %0d avg %0d",
                     $time, got.phase, got.phase_changed, got.average_pressure);
            errors++;
            return;
        end
        e = expected_phases.pop_front();
        if (got.phase !== e.phase) begin
            $display("%0t: phase expected %0d actual %0d", $time, e.phase, got.phase);
            errors++;
        end
        if (got.phase_changed !== e.phase_changed) begin
            $display("%0t: phase_changed expected %0d actual %0d",
                     $time, e.phase_changed, got.phase_changed);
            errors++;
        end
        if (got.average_pressure !== e.average_pressure) begin
            $display("%0t: average_pressure expected %0d actual %0d",
                     $time, e.average_pressure, got.average_pressure);
            errors++;
        end
    endfunction

    function int pending();
        return expected_phases.size();
    endfunction
endclass

module tb_flight_phase_sequencer;

    localparam int SETTINGS_RUN   = 6;
    localparam int ITEMS_PER_RUN  = 255;
    localparam int PAUSE_AT       = 60;
    localparam int TAIL_CYCLES    = 40;
    localparam int LIMIT_CYCLES   = 500000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_item               i_in_item;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_item              o_out_item;

    phase_scoreboard sb = new();
    logic [31:0]     tick;
    bit              calm_in;
    bit              calm_out;
    int unsigned     cycles;

    flight_phase_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // Presents one transaction after a random gap and returns at the edge that takes it.
    task automatic send_item(t_in_item it);
        int gap;
        if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_input(it);
    endtask

    task automatic send_fields(logic act, logic [2:0] forced, logic [31:0] now,
                               logic [7:0] cmd, logic [15:0] press);
        t_in_item it;
        it.action          = act;
        it.forced_phase    = forced;
        it.now_ms          = now;
        it.last_command    = cmd;
        it.pressure_sample = press;
        send_item(it);
    endtask

    // Holds off input until every outstanding result has been taken.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_config(logic [31:0] burn, logic [31:0] descent, logic [7:0] code);
        logic [CFG_DATA_W-1:0] vals [3];
        logic [CFG_INDEX_W-1:0] idx [3];
        vals[0] = burn;
        vals[1] = descent;
        vals[2] = 32'(code);
        idx[0]  = CFG_BURN_TIME;
        idx[1]  = CFG_DESCENT_TIME;
        idx[2]  = CFG_LAUNCH_CODE;
        for (int k = 0; k < 3; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= vals[k];
            sb.set_reg(idx[k], vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly well-formed flight sequences driven from the predicted phase, with some noise.
    function automatic t_in_item next_stimulus();
        t_in_item it;
        int       roll;
        roll               = $urandom_range(0, 99);
        tick               = tick + 32'($urandom_range(0, 2000));
        it.action          = ACT_EVALUATE;
        it.forced_phase    = 3'($urandom_range(0, 7));
        it.now_ms          = tick;
        it.last_command    = 8'($urandom);
        it.pressure_sample = 16'($urandom);
        if (roll < 8) begin
            it.action = 1'($urandom);
            it.now_ms = $urandom;
        end else if (roll < 14) begin
            it.action = ACT_FORCE;
        end else begin
            case (sb.phase)
                PH_WAITING: begin
                    if (roll < 65) it.last_command = sb.launch_cmd;
                end
                PH_POWERED: begin
                    if (roll < 60)
                        it.now_ms = sb.entered_at + sb.burn_ms
                                    + 32'($urandom_range(0, 4)) - 32'd2;
                end
                PH_COAST: begin
                    if (roll < 22)
                        it.pressure_sample = 16'h0000;
                    else if (roll < 30)
                        it.pressure_sample = 16'hFFFF;
                    else
                        it.pressure_sample = 16'(32'd40000 + $urandom_range(0, 4095));
                end
                PH_DESCENT: begin
                    if (roll < 60)
                        it.now_ms = sb.entered_at + sb.descent_ms
                                    + 32'($urandom_range(0, 4)) - 32'd2;
                end
                default: begin
                    // Landed and abort only leave by force.
                    if (roll < 75) begin
                        it.action       = ACT_FORCE;
                        it.forced_phase = 3'($urandom_range(0, 5));
                    end
                end
            endcase
        end
        return it;
    endfunction

    initial begin
        i_out_stall <= 1'b1;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            int gap;
            if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
            gap = calm_out ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
            sb.check_result(o_out_item);
        end
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [31:0] burn;
        logic [31:0] descent;
        logic [7:0]  code;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through a whole flight at the reset configuration.
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd0, 8'd0, 16'd0);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd100, 8'd8, 16'd0);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd5100, 8'd0, 16'd0);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd5101, 8'd0, 16'd0);
        // A zero average must not arm the apogee test.
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd5150, 8'd0, 16'h0000);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd5160, 8'd0, 16'hFFFF);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd5200, 8'd0, 16'hFFFF);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd305200, 8'd0, 16'd0);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd305201, 8'd0, 16'd0);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd305300, 8'd8, 16'd0);
        // Phase codes beyond abort are ignored.
        send_fields(ACT_FORCE, 3'd6, 32'd305400, 8'd0, 16'd0);
        send_fields(ACT_FORCE, 3'd7, 32'd305500, 8'd0, 16'd0);
        send_fields(ACT_FORCE, PH_ABORT, 32'd400000, 8'd0, 16'd0);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd900000, 8'd8, 16'd0);
        send_fields(ACT_FORCE, PH_ABORT, 32'd900001, 8'd0, 16'd0);
        // Coast entered again keeps the old window contents.
        send_fields(ACT_FORCE, PH_COAST, 32'hFFFF_FFFF, 8'd0, 16'd0);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'd10, 8'd0, 16'hFFFF);
        // Elapsed time across the 32-bit wrap.
        send_fields(ACT_FORCE, PH_POWERED, 32'hFFFF_FF00, 8'd0, 16'd0);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'h0000_1300, 8'd0, 16'd0);
        send_fields(ACT_FORCE, PH_WAITING, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_fields(ACT_EVALUATE, 3'd7, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send_fields(ACT_FORCE, PH_LANDED, 32'd1, 8'd0, 16'd0);
        send_fields(ACT_FORCE, PH_DESCENT, 32'd0, 8'd0, 16'd0);
        send_fields(ACT_EVALUATE, PH_WAITING, 32'hFFFF_FFFF, 8'd0, 16'd0);
        send_fields(ACT_FORCE, PH_WAITING, 32'd0, 8'd0, 16'd0);

        for (int s = 0; s < SETTINGS_RUN; s++) begin
            drain();
            burn    = sb.burn_ms;
            descent = sb.descent_ms;
            code    = sb.launch_cmd;
            case (s)
                1: begin burn = '0; descent = '0; code = '0; end
                2: begin burn = '1; descent = '1; code = '1; end
                3: begin burn = 32'd1; descent = 32'd1; code = 8'($urandom); end
                4: begin
                    burn    = $urandom_range(0, 8000);
                    descent = $urandom_range(0, 400000);
                    code    = 8'($urandom);
                end
                5: begin burn = $urandom; descent = $urandom; code = 8'($urandom); end
                default: ;
            endcase
            if (s != 0) write_config(burn, descent, code);
            tick = s[0] ? 32'hFFFF_0000 + 32'($urandom_range(0, 65535)) : $urandom;
            for (int n = 0; n < ITEMS_PER_RUN; n++) begin
                if (n == PAUSE_AT) drain();
                send_item(next_stimulus());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
